### hw/rtl/lcsr_pkg.sv
// Package for the LED cube serial refresh unit.
// Holds the shared constants, action codes, state type and controller command types.
// Used by lcsr_ctrl, lcsr_datapath and led_cube_serial_refresh_unit; depends on nothing.
package lcsr_pkg;

   // Cube geometry.
   localparam int CUBE_SIDE = 4;
   localparam int COORD_W   = 2;
   localparam int LAYER_PIX = CUBE_SIDE * CUBE_SIDE;
   localparam int PIXELS    = LAYER_PIX * CUBE_SIDE;
   localparam int PIX_IDX_W = 3 * COORD_W;
   localparam logic [COORD_W-1:0] LAYER_LAST = COORD_W'(CUBE_SIDE - 1);

   // Frame shifting. The shift register holds the frame without its start bit:
   // the 16 pixel bits and the one-hot layer select above them.
   localparam int SHIFT_W = LAYER_PIX + CUBE_SIDE;
   localparam int CNT_W   = 6;
   localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(35);

   // Action codes of an input beat.
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // Refresh sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DATA_FRAME,
      ST_GAP_A,
      ST_CLEAR_FRAME,
      ST_GAP_B
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                accept;
      logic                wr_pixel;
      logic                load_frame;
      logic                load_clear;
      logic                shift;
      logic [COORD_W-1:0]  layer;
      logic                clock_pulse;
      logic                enable_n;
      logic                busy;
      logic                done;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hold;
   } status_type;

endpackage

### hw/rtl/led_cube_serial_refresh_unit.sv
// LED cube serial refresh unit, top level.
// Instantiates lcsr_ctrl and lcsr_datapath; depends on lcsr_pkg.
//
// The unit keeps a 4x4x4 pixel map, all off after reset, and drives a serial LED driver
// one step per tick beat. Every input beat (write pixel, start refresh, tick) gives
// exactly one result beat, in the cycle after it is taken, and a new beat is taken every
// cycle while the result register is free or being emptied; the rate is set by that
// single result register. A full refresh takes 296 tick beats: for each of the four
// layers, a 36-bit data frame, an idle tick, a 36-bit clear frame and a second idle
// tick. Each layer's frame is taken from the pixel map on its first tick, so writes
// during a refresh show in later layers. Starts while busy are ignored.
module led_cube_serial_refresh_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [lcsr_pkg::COORD_W-1:0]      req_layer,
   input  logic [lcsr_pkg::COORD_W-1:0]      req_row,
   input  logic [lcsr_pkg::COORD_W-1:0]      req_column,
   input  logic                              req_lit,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_serial_data,
   output logic                              rsp_clock_pulse,
   output logic                              rsp_enable_n,
   output logic                              rsp_busy_res,
   output logic                              rsp_refresh_done
);

   lcsr_pkg::cmd_type      cmd;
   lcsr_pkg::status_type   status;

   // Refresh sequencer.
   lcsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .status     (status),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   // Pixel map, frame shifter and result register.
   lcsr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_layer        (req_layer),
      .req_row          (req_row),
      .req_column       (req_column),
      .req_lit          (req_lit),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_serial_data  (rsp_serial_data),
      .rsp_clock_pulse  (rsp_clock_pulse),
      .rsp_enable_n     (rsp_enable_n),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_refresh_done (rsp_refresh_done)
   );

endmodule

### hw/rtl/lcsr_ctrl.sv
// Refresh controller of the LED cube serial refresh unit.
// Sequences frames, gaps and layers and issues commands to the datapath.
// Depends on lcsr_pkg.
module lcsr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [1:0]                  req_action,
   input  lcsr_pkg::status_type        status,
   output logic                        req_stall,
   output lcsr_pkg::cmd_type           cmd
);

   lcsr_pkg::state_type                state_ff, state_in;
   logic [lcsr_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [lcsr_pkg::COORD_W-1:0]       layer_ff, layer_in;
   logic                               accept;
   logic                               tick;
   logic                               start;
   logic                               cnt_last;

   // A beat is taken whenever the output register can take its result.
   assign req_stall = status.hold;
   assign accept    = req_valid && !status.hold;
   assign tick      = accept && (req_action == lcsr_pkg::ACT_TICK);
   assign start     = accept && (req_action == lcsr_pkg::ACT_START);
   assign cnt_last  = (cnt_ff == lcsr_pkg::FRAME_LAST);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcsr_pkg::ST_IDLE: begin
            if (start) state_in = lcsr_pkg::ST_DATA_FRAME;
         end
         lcsr_pkg::ST_DATA_FRAME: begin
            if (tick && cnt_last) state_in = lcsr_pkg::ST_GAP_A;
         end
         lcsr_pkg::ST_GAP_A: begin
            if (tick) state_in = lcsr_pkg::ST_CLEAR_FRAME;
         end
         lcsr_pkg::ST_CLEAR_FRAME: begin
            if (tick && cnt_last) state_in = lcsr_pkg::ST_GAP_B;
         end
         lcsr_pkg::ST_GAP_B: begin
            if (tick) begin
               state_in = (layer_ff == lcsr_pkg::LAYER_LAST) ? lcsr_pkg::ST_IDLE
                                                             : lcsr_pkg::ST_DATA_FRAME;
            end
         end
         default: state_in = lcsr_pkg::ST_IDLE;
      endcase
   end

   // Bit and layer counters.
   always_comb begin
      cnt_in   = cnt_ff;
      layer_in = layer_ff;
      case (state_ff)
         lcsr_pkg::ST_IDLE: begin
            if (start) begin
               cnt_in   = '0;
               layer_in = '0;
            end
         end
         lcsr_pkg::ST_DATA_FRAME, lcsr_pkg::ST_CLEAR_FRAME: begin
            if (tick) cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         lcsr_pkg::ST_GAP_B: begin
            if (tick) begin
               layer_in = (layer_ff == lcsr_pkg::LAYER_LAST) ? '0 : layer_ff + 1'b1;
            end
         end
         default: begin
            cnt_in   = cnt_ff;
            layer_in = layer_ff;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.wr_pixel    = accept && (req_action == lcsr_pkg::ACT_WRITE);
      cmd.layer       = layer_ff;
      cmd.enable_n    = 1'b1;
      cmd.busy        = (state_ff != lcsr_pkg::ST_IDLE);
      case (state_ff)
         lcsr_pkg::ST_IDLE: begin
            if (start) cmd.busy = 1'b1;
         end
         lcsr_pkg::ST_DATA_FRAME: begin
            if (tick) begin
               cmd.load_frame  = (cnt_ff == '0);
               cmd.shift       = (cnt_ff != '0);
               cmd.clock_pulse = 1'b1;
               cmd.enable_n    = 1'b0;
            end
         end
         lcsr_pkg::ST_CLEAR_FRAME: begin
            if (tick) begin
               cmd.load_clear  = (cnt_ff == '0);
               cmd.shift       = (cnt_ff != '0);
               cmd.clock_pulse = 1'b1;
               cmd.enable_n    = 1'b0;
            end
         end
         lcsr_pkg::ST_GAP_B: begin
            cmd.done = tick && (layer_ff == lcsr_pkg::LAYER_LAST);
         end
         default: begin
            cmd.done = 1'b0;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcsr_pkg::ST_IDLE;
         cnt_ff   <= '0;
         layer_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         layer_ff <= layer_in;
      end
   end

`ifndef SYNTHESIS
   // The refresh ends only on the last layer's closing gap tick.
   a_done_last_layer: assert property (@(posedge clock) disable iff (reset)
      cmd.done |-> (state_ff == lcsr_pkg::ST_GAP_B) && (layer_ff == lcsr_pkg::LAYER_LAST))
      else $error("refresh done outside the last layer gap");

   // A frame is loaded only on its first bit.
   a_load_first_bit: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_frame || cmd.load_clear) |-> (cnt_ff == '0))
      else $error("frame load away from the first bit");

   // The bit counter is parked at zero outside the frames.
   a_cnt_parked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcsr_pkg::ST_IDLE || state_ff == lcsr_pkg::ST_GAP_A ||
       state_ff == lcsr_pkg::ST_GAP_B) |-> (cnt_ff == '0))
      else $error("bit counter not parked between frames");

   // Finishing a refresh returns the sequencer to idle.
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.done |=> (state_ff == lcsr_pkg::ST_IDLE))
      else $error("sequencer not idle after refresh done");
`endif

endmodule

### hw/rtl/lcsr_datapath.sv
// Datapath of the LED cube serial refresh unit.
// Holds the pixel map, the frame shift register and the result register.
// Depends on lcsr_pkg; driven by commands from lcsr_ctrl.
module lcsr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lcsr_pkg::cmd_type                 cmd,
   input  logic [lcsr_pkg::COORD_W-1:0]      req_layer,
   input  logic [lcsr_pkg::COORD_W-1:0]      req_row,
   input  logic [lcsr_pkg::COORD_W-1:0]      req_column,
   input  logic                              req_lit,
   input  logic                              rsp_stall,
   output lcsr_pkg::status_type              status,
   output logic                              rsp_valid,
   output logic                              rsp_serial_data,
   output logic                              rsp_clock_pulse,
   output logic                              rsp_enable_n,
   output logic                              rsp_busy_res,
   output logic                              rsp_refresh_done
);

   logic [lcsr_pkg::PIXELS-1:0]              pixel_ff, pixel_in;
   logic [lcsr_pkg::SHIFT_W-1:0]             shift_ff, shift_in;
   logic [lcsr_pkg::SHIFT_W-1:0]             frame_word;
   logic [lcsr_pkg::PIX_IDX_W-1:0]           wr_idx;
   logic [lcsr_pkg::PIX_IDX_W-1:0]           layer_base;
   logic [lcsr_pkg::CUBE_SIDE-1:0]           layer_sel;
   logic                                     data_bit;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     serial_data_ff;
   logic                                     clock_pulse_ff;
   logic                                     enable_n_ff;
   logic                                     busy_res_ff;
   logic                                     refresh_done_ff;

   // Pixel map write: one bit at {layer, row, column}.
   assign wr_idx = {req_layer, req_row, req_column};

   always_comb begin
      pixel_in = pixel_ff;
      if (cmd.wr_pixel) pixel_in[wr_idx] = req_lit;
   end

   // Frame of the current layer, without its start bit.
   assign layer_base = {cmd.layer, {(lcsr_pkg::PIX_IDX_W - lcsr_pkg::COORD_W){1'b0}}};
   assign layer_sel  = lcsr_pkg::CUBE_SIDE'(1) << cmd.layer;
   assign frame_word = {layer_sel, pixel_ff[layer_base +: lcsr_pkg::LAYER_PIX]};

   // Frame shift register. The start bit goes out directly on a load.
   always_comb begin
      shift_in = shift_ff;
      if (cmd.load_frame) begin
         shift_in = frame_word;
      end else if (cmd.load_clear) begin
         shift_in = '0;
      end else if (cmd.shift) begin
         shift_in = shift_ff >> 1;
      end
   end

   always_comb begin
      if (cmd.load_frame || cmd.load_clear) begin
         data_bit = 1'b1;
      end else if (cmd.shift) begin
         data_bit = shift_ff[0];
      end else begin
         data_bit = 1'b0;
      end
   end

   // Result register: holds a beat until the receiver takes it.
   assign status.hold  = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in = cmd.accept || status.hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff     <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pixel_ff     <= pixel_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         serial_data_ff  <= data_bit;
         clock_pulse_ff  <= cmd.clock_pulse;
         enable_n_ff     <= cmd.enable_n;
         busy_res_ff     <= cmd.busy;
         refresh_done_ff <= cmd.done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_serial_data  = serial_data_ff;
   assign rsp_clock_pulse  = clock_pulse_ff;
   assign rsp_enable_n     = enable_n_ff;
   assign rsp_busy_res     = busy_res_ff;
   assign rsp_refresh_done = refresh_done_ff;

endmodule
